/* rtl/fbfl_pkg.sv */
// fbfl_pkg: shared types and codes for the fixed block free list allocator
// depends on nothing; imported by every module of the block
package fbfl_pkg;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_BAD   = 2'd2
  } status_e;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned CountW    = 11;
  localparam int unsigned SizeW     = 16;
  localparam int unsigned IndexW    = 10;
  localparam int unsigned OffsetW   = 26;

  localparam logic [CfgIdxW-1:0] CFG_BLOCK_COUNT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BLOCK_SIZE  = 2'd1;

  localparam logic [CountW-1:0] BlockCountRst = 11'd1024;
  localparam logic [SizeW-1:0]  BlockSizeRst  = 16'd8;

  typedef struct packed {
    logic              operation;
    logic [IndexW-1:0] block_index;
  } req_t;

  typedef struct packed {
    logic [IndexW-1:0]  granted_index;
    logic [OffsetW-1:0] granted_offset;
    status_e            status;
  } res_t;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

/* rtl/fbfl_ctrl.sv */
// fbfl_ctrl: two-state controller that sequences one transaction at a time
// depends on fbfl_pkg; drives the datapath through cmd_t
module fbfl_ctrl
  import fbfl_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  output logic done_o,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   done_q, done_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b0;
    done_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load = start_i;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        busy_o     = 1'b1;
        done_d     = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign done_o = done_q;

endmodule

/* rtl/fbfl_dp.sv */
// fbfl_dp: config registers, list head, watermark, next-link memory and result register
// depends on fbfl_pkg; commanded by fbfl_ctrl
module fbfl_dp
  import fbfl_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  input  req_t                req_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output res_t                res_o
);

  localparam int unsigned AddrW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned PtrW  = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned CmpW  = (PtrW > CountW) ? PtrW : CountW;
  localparam int unsigned ProdW = PtrW + SizeW;
  localparam logic [PtrW-1:0] NullLink = PtrW'(MAX_BLOCKS);

  logic [CountW-1:0] block_count_q;
  logic [SizeW-1:0]  block_size_q;
  logic [PtrW-1:0]   head_q, head_d;
  logic [PtrW-1:0]   mark_q, mark_d;
  req_t              req_q;
  logic [PtrW-1:0]   next_link_q [MAX_BLOCKS];
  logic [PtrW-1:0]   link_rd_q;
  res_t              res_q;

  logic [PtrW-1:0]   count;
  logic [PtrW-1:0]   grant;
  logic              granted;
  status_e           status;
  logic              link_we;
  logic [ProdW-1:0]  prod;

  assign count = (CmpW'(block_count_q) > CmpW'(MAX_BLOCKS)) ? PtrW'(MAX_BLOCKS)
                                                           : PtrW'(block_count_q);

  always_comb begin
    head_d  = head_q;
    mark_d  = mark_q;
    grant   = '0;
    granted = 1'b0;
    status  = STAT_OK;
    link_we = 1'b0;
    if (req_q.operation == OP_ALLOC) begin
      priority if (head_q < count) begin
        grant   = head_q;
        head_d  = link_rd_q;
        granted = 1'b1;
      end else if (mark_q < count) begin
        grant   = mark_q;
        mark_d  = mark_q + PtrW'(1);
        granted = 1'b1;
      end else begin
        status = STAT_EMPTY;
      end
    end else begin
      if (CmpW'(req_q.block_index) >= CmpW'(count)) begin
        status = STAT_BAD;
      end else begin
        link_we = 1'b1;
        head_d  = PtrW'(req_q.block_index);
      end
    end
  end

  assign prod = ProdW'(grant) * ProdW'(block_size_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_count_q <= BlockCountRst;
      block_size_q  <= BlockSizeRst;
      head_q        <= NullLink;
      mark_q        <= '0;
    end else begin
      priority if (cfg_we_i && cfg_index_i == CFG_BLOCK_COUNT) begin
        block_count_q <= cfg_data_i[CountW-1:0];
        head_q        <= NullLink;
        mark_q        <= '0;
      end else if (cfg_we_i && cfg_index_i == CFG_BLOCK_SIZE) begin
        block_size_q <= cfg_data_i[SizeW-1:0];
      end else if (cmd_i.exec) begin
        head_q <= head_d;
        mark_q <= mark_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q     <= req_i;
      link_rd_q <= next_link_q[AddrW'(head_q)];
    end
    if (cmd_i.exec && link_we) begin
      next_link_q[AddrW'(req_q.block_index)] <= head_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_q.granted_index  <= granted ? IndexW'(grant) : '0;
      res_q.granted_offset <= granted ? OffsetW'(prod) : '0;
      res_q.status         <= status;
    end
  end

  assign res_o = res_q;

endmodule

/* rtl/fixed_block_free_list_allocator.sv */
// Fixed block free list allocator. One transaction is taken when start is high and busy is
// low; done_o is high for exactly one cycle with its result on res_o, registered at the end
// of the execute state that follows acceptance, and the result cannot be held off. A new
// transaction may be started in the cycle the previous result is shown but not while busy;
// execute uses the registered read of the next-link memory that a pop needs to move the head.
// Allocate pops the free list head, or the lowest never-used block, and reports out of
// blocks when neither exists; free pushes an index, or reports a bad index at or above the
// pool size. Writing block_count returns every block to the pool. Configure only while idle.
module fixed_block_free_list_allocator
  import fbfl_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  req_t                req_i,
  output logic                done_o,
  output res_t                res_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cmd_t cmd;

  fbfl_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  fbfl_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .res_o       (res_o)
  );

endmodule

/* rtl/fbfl_checker.sv */
// fbfl_checker: port-level checks of the allocator's sequencing and result codes
// depends on fbfl_pkg; bound to fixed_block_free_list_allocator
module fbfl_checker
  import fbfl_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input res_t res_o
);

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted transaction did not make the block busy");

  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> done_o && !busy)
    else $error("transaction did not complete after one busy cycle");

  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result strobe without a transaction in flight");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.status != STAT_OK |-> res_o.granted_index == '0
                                         && res_o.granted_offset == '0)
    else $error("failed transaction reported a nonzero grant");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> res_o.status == STAT_OK || res_o.status == STAT_EMPTY
               || res_o.status == STAT_BAD)
    else $error("undefined status code");

endmodule

bind fixed_block_free_list_allocator fbfl_checker u_fbfl_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .res_o  (res_o)
);

/* tb/tb.sv */
// tb: self-checking testbench for fixed_block_free_list_allocator
// drives allocate and free transactions plus register writes, predicts every result
// from its own free list copy; depends on fbfl_pkg and the allocator rtl
`timescale 1ns / 1ps

module tb;
  import fbfl_pkg::*;

  localparam int unsigned MaxBlocks = 1024;
  localparam int unsigned NullLink = MaxBlocks;
  localparam logic [CfgIdxW-1:0] CfgUnusedA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgUnusedB = 2'd3;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  req_t                req_i = '0;
  logic                done_o;
  res_t                res_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  // allocator state as the testbench sees it
  int unsigned pool_count = 1024;
  int unsigned blk_size = 8;
  int unsigned link_mem [MaxBlocks];
  int unsigned list_head = NullLink;
  int unsigned unused_mark = 0;

  res_t              pending_grants [$];
  logic [IndexW-1:0] held_blocks [$];
  bit                gaps_on = 1'b1;

  int mismatch_cnt = 0;
  int sent_cnt = 0;
  int checked_cnt = 0;
  int ok_cnt = 0;
  int empty_cnt = 0;
  int bad_cnt = 0;
  int setting_cnt = 1;

  fixed_block_free_list_allocator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .done_o     (done_o),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #3_000_000;
    $display("tb NOT OK");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch: %s got %0d expected %0d", what, got, want);
    mismatch_cnt++;
  endtask

  function automatic res_t predict_outcome(input op_e op, input logic [IndexW-1:0] idx);
    int unsigned cnt;
    int unsigned grant;
    int unsigned offset_full;
    bit          granted;
    res_t        r;
    cnt = (pool_count > MaxBlocks) ? MaxBlocks : pool_count;
    grant = 0;
    granted = 1'b0;
    r = '0;
    r.status = STAT_OK;
    if (op == OP_ALLOC) begin
      if (list_head < cnt && list_head < MaxBlocks) begin
        grant = list_head;
        list_head = link_mem[grant];
        granted = 1'b1;
      end else if (unused_mark < cnt) begin
        grant = unused_mark;
        unused_mark++;
        granted = 1'b1;
      end else begin
        r.status = STAT_EMPTY;
      end
    end else if (idx >= cnt) begin
      r.status = STAT_BAD;
    end else begin
      link_mem[idx] = list_head;
      list_head = idx;
    end
    if (granted) begin
      offset_full = grant * blk_size;
      r.granted_index = grant[IndexW-1:0];
      r.granted_offset = offset_full[OffsetW-1:0];
    end
    return r;
  endfunction

  always @(posedge clk_i) begin : check_results
    res_t want;
    if (rst_ni && done_o) begin
      if (pending_grants.size() == 0) begin
        report_mismatch("result with no transaction pending, status", res_o.status, 0);
      end else begin
        want = pending_grants.pop_front();
        checked_cnt++;
        if (res_o.granted_index !== want.granted_index)
          report_mismatch("granted_index", res_o.granted_index, want.granted_index);
        if (res_o.granted_offset !== want.granted_offset)
          report_mismatch("granted_offset", res_o.granted_offset, want.granted_offset);
        if (res_o.status !== want.status)
          report_mismatch("status", res_o.status, want.status);
      end
    end
  end

  task automatic issue_request(input op_e op, input logic [IndexW-1:0] idx);
    res_t want;
    int   gap;
    if (gaps_on && $urandom_range(99) < 35) begin
      gap = $urandom_range(1, 2);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= '{operation: op, block_index: idx};
    do @(posedge clk_i); while (busy);
    want = predict_outcome(op, idx);
    pending_grants.push_back(want);
    sent_cnt++;
    case (want.status)
      STAT_OK: begin
        if (op == OP_ALLOC) begin
          held_blocks.push_back(want.granted_index);
          ok_cnt++;
        end
      end
      STAT_EMPTY: empty_cnt++;
      default: bad_cnt++;
    endcase
  endtask

  task automatic alloc_block();
    issue_request(OP_ALLOC, IndexW'($urandom));
  endtask

  task automatic free_block(input logic [IndexW-1:0] idx);
    issue_request(OP_FREE, idx);
  endtask

  task automatic wait_idle();
    res_t left;
    start <= 1'b0;
    for (int w = 0; w < 64 && pending_grants.size() != 0; w++) @(posedge clk_i);
    while (pending_grants.size() != 0) begin
      left = pending_grants.pop_front();
      report_mismatch("result never arrived, status", 0, left.status);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx,
                                input logic [CfgDataW-1:0] data);
    wait_idle();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_BLOCK_COUNT) begin
      pool_count = data[CountW-1:0];
      list_head = NullLink;
      unused_mark = 0;
      held_blocks.delete();
      setting_cnt++;
    end else if (idx == CFG_BLOCK_SIZE) begin
      blk_size = data;
    end
  endtask

  task automatic test_reset_pool();
    alloc_block();
    alloc_block();
    free_block(10'd1);
    free_block(10'd1023);
    alloc_block();
    alloc_block();
  endtask

  task automatic test_double_free();
    free_block(10'd0);
    free_block(10'd0);
    alloc_block();
    alloc_block();
    write_register(CFG_BLOCK_SIZE, 16'hFFFF);
    free_block(10'd1023);
    alloc_block();
  endtask

  task automatic test_empty_pool();
    write_register(CFG_BLOCK_COUNT, 16'd0);
    alloc_block();
    free_block(10'd0);
    free_block(10'd1023);
  endtask

  task automatic test_small_pool();
    write_register(CFG_BLOCK_COUNT, 16'd2);
    write_register(CFG_BLOCK_SIZE, 16'd1);
    alloc_block();
    alloc_block();
    alloc_block();
    free_block(10'd2);
    write_register(CFG_BLOCK_SIZE, 16'd3);
    write_register(CfgUnusedA, 16'hFFFF);
    write_register(CfgUnusedB, 16'h0001);
    free_block(10'd1);
    alloc_block();
  endtask

  task automatic test_count_saturation();
    write_register(CFG_BLOCK_COUNT, 16'd2047);
    free_block(10'd1023);
    alloc_block();
    alloc_block();
  endtask

  task automatic run_phase(input int unsigned cnt, input int unsigned sz, input int items,
                           input int free_pct);
    int r;
    int k;
    write_register(CFG_BLOCK_COUNT, CfgDataW'(cnt));
    write_register(CFG_BLOCK_SIZE, CfgDataW'(sz));
    for (int i = 0; i < items; i++) begin
      r = $urandom_range(99);
      if (held_blocks.size() != 0 && r < free_pct) begin
        k = $urandom_range(held_blocks.size() - 1);
        free_block(held_blocks[k]);
        held_blocks.delete(k);
      end else if (r < free_pct + 10) begin
        free_block(IndexW'($urandom));
      end else begin
        alloc_block();
      end
    end
  endtask

  task automatic test_random_traffic();
    run_phase(16, 1, 120, 40);
    gaps_on = 1'b0;
    run_phase(1024, 65535, 120, 30);
    gaps_on = 1'b1;
    run_phase(0, $urandom_range(1, 65535), 30, 40);
    run_phase(1, 8, 60, 40);
    run_phase($urandom_range(2, 64), $urandom_range(1, 65535), 100, 45);
    run_phase(2047, $urandom_range(1, 65535), 100, 35);
    run_phase($urandom_range(65, 1023), $urandom_range(1, 65535), 95, 40);
  endtask

  initial begin
    for (int i = 0; i < MaxBlocks; i++) link_mem[i] = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_reset_pool();
    test_double_free();
    test_empty_pool();
    test_small_pool();
    test_count_saturation();
    test_random_traffic();
    wait_idle();
    $display("sent %0d transactions under %0d pool sizes, %0d results checked",
             sent_cnt, setting_cnt, checked_cnt);
    $display("grants %0d, out of blocks %0d, bad frees %0d, mismatches %0d",
             ok_cnt, empty_cnt, bad_cnt, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/fbfl_pkg.sv
rtl/fbfl_ctrl.sv
rtl/fbfl_dp.sv
rtl/fixed_block_free_list_allocator.sv
rtl/fbfl_checker.sv
tb/tb.sv
